// File: src/fpms_pkg.sv
// Shared widths, constants and controller interface types for the frame mean/std block.
package fpms_pkg;

  // Field and accumulator widths.
  localparam int unsigned PixW   = 8;
  localparam int unsigned CntW   = 21;
  localparam int unsigned SumW   = 28;
  localparam int unsigned SqSumW = 36;
  localparam int unsigned MeanW  = 16;
  localparam int unsigned StdW   = 15;

  // Packed stream widths: mean, std and pixel total, padded to whole bytes.
  localparam int unsigned OutFieldsW = MeanW + StdW + CntW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Pixel limit per frame.
  localparam logic [CntW-1:0] MaxPixels = 21'd1048576;

  // Post-processing datapath widths.
  localparam int unsigned ProdW = 56;           // n*Q and S*S both fit in 56 bits
  localparam int unsigned DivW  = ProdW + 16;   // dividend of 65536*V
  localparam int unsigned RadW  = 32;           // variance in Q16.16 stays below 2^30
  localparam int unsigned RootW = RadW / 2;

  // Iteration counts of the multiplier, divider and root unit.
  localparam int unsigned MulSteps  = CntW;
  localparam int unsigned DivSteps  = DivW;
  localparam int unsigned RootSteps = RootW;
  localparam int unsigned StepW     = $clog2(DivSteps);

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_VAR,
    ST_DIV_VAR,
    ST_DIV_REDO,
    ST_DIV_NORM,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_DIV_MEAN,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic snap;       // take the finished frame's accumulators, clear them
    logic mul_step;   // one shift-add step of n*Q
    logic var_load;   // form V and load the divider with 65536*V
    logic div_redo;   // restart the divider on its own quotient
    logic div_step;   // one restoring division step
    logic root_load;  // load the root unit and load the divider with 256*S
    logic root_step;  // one digit of the square root
    logic out_load;   // write the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic end_pend;   // a frame has ended and waits for its snapshot
    logic out_free;   // the result register can take a new result
  } status_t;

endpackage

// File: src/frame_pixel_mean_and_std_top.sv
// Top level of the frame pixel mean and standard deviation block.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] pixel; tlast marks the frame's final pixel
//  m_axis    out        tdata[15:0] mean_q8, [30:16] std_q8, [51:31] pixel_total,
//                       [55:52] zero; tuser overflow
//
// Pixels are taken one per cycle while tready is high. A pixel with tlast
// holds tready low while the frame's sums are copied out, then input streams
// on while the result is computed: 21 multiply steps, two 72-step divisions,
// 16 root steps and a 72-step mean division. A second frame ending before the
// result is written stalls input until done.
// Reset is asynchronous and clears the sums; a waiting result holds until taken.
module frame_pixel_mean_and_std_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fpms_pkg::PixW-1:0]     s_axis_tdata,   // [7:0] pixel
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fpms_pkg::OutDataW-1:0] m_axis_tdata,   // mean_q8, std_q8, pixel_total
  output logic                          m_axis_tuser    // [0] overflow
);

  fpms_pkg::cmd_t    cmd;
  fpms_pkg::status_t status;

  fpms_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  fpms_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: src/fpms_ctrl.sv
// Controller state machine sequencing the per-frame multiply, divides and square root.
module fpms_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fpms_pkg::status_t status_i,
  output fpms_pkg::cmd_t    cmd_o
);

  fpms_pkg::state_e state_q, state_d;
  logic [fpms_pkg::StepW-1:0] step_q, step_d;
  logic mul_done, div_done, root_done;

  // Last iteration of each unit.
  assign mul_done  = (step_q == fpms_pkg::StepW'(fpms_pkg::MulSteps - 1));
  assign div_done  = (step_q == fpms_pkg::StepW'(fpms_pkg::DivSteps - 1));
  assign root_done = (step_q == fpms_pkg::StepW'(fpms_pkg::RootSteps - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpms_pkg::ST_IDLE:      if (status_i.end_pend) state_d = fpms_pkg::ST_MUL;
      fpms_pkg::ST_MUL:       if (mul_done) state_d = fpms_pkg::ST_VAR;
      fpms_pkg::ST_VAR:       state_d = fpms_pkg::ST_DIV_VAR;
      fpms_pkg::ST_DIV_VAR:   if (div_done) state_d = fpms_pkg::ST_DIV_REDO;
      fpms_pkg::ST_DIV_REDO:  state_d = fpms_pkg::ST_DIV_NORM;
      fpms_pkg::ST_DIV_NORM:  if (div_done) state_d = fpms_pkg::ST_ROOT_LOAD;
      fpms_pkg::ST_ROOT_LOAD: state_d = fpms_pkg::ST_ROOT;
      fpms_pkg::ST_ROOT:      if (root_done) state_d = fpms_pkg::ST_DIV_MEAN;
      fpms_pkg::ST_DIV_MEAN:  if (div_done) state_d = fpms_pkg::ST_OUT;
      fpms_pkg::ST_OUT:       if (status_i.out_free) state_d = fpms_pkg::ST_IDLE;
      default:                state_d = fpms_pkg::ST_IDLE;
    endcase
  end

  // Iteration counter restarts on every state change.
  always_comb begin
    if (state_d != state_q) begin
      step_d = '0;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      fpms_pkg::ST_IDLE:      cmd_o.snap      = status_i.end_pend;
      fpms_pkg::ST_MUL:       cmd_o.mul_step  = 1'b1;
      fpms_pkg::ST_VAR:       cmd_o.var_load  = 1'b1;
      fpms_pkg::ST_DIV_VAR:   cmd_o.div_step  = 1'b1;
      fpms_pkg::ST_DIV_REDO:  cmd_o.div_redo  = 1'b1;
      fpms_pkg::ST_DIV_NORM:  cmd_o.div_step  = 1'b1;
      fpms_pkg::ST_ROOT_LOAD: cmd_o.root_load = 1'b1;
      fpms_pkg::ST_ROOT:      cmd_o.root_step = 1'b1;
      fpms_pkg::ST_DIV_MEAN:  cmd_o.div_step  = 1'b1;
      fpms_pkg::ST_OUT:       cmd_o.out_load  = status_i.out_free;
      default:                cmd_o = '0;
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpms_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: src/fpms_dp.sv
// Datapath: pixel accumulators, frame snapshot, shift-add multiplier, divider, root unit.
module fpms_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fpms_pkg::cmd_t                  cmd_i,
  output fpms_pkg::status_t               status_o,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [fpms_pkg::PixW-1:0]       s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fpms_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser
);

  // Running accumulators of the current frame.
  logic [fpms_pkg::CntW-1:0]   acc_cnt_q;
  logic [fpms_pkg::SumW-1:0]   acc_sum_q;
  logic [fpms_pkg::SqSumW-1:0] acc_sq_q;
  logic                        acc_ovf_q;
  logic                        end_pend_q;
  logic                        in_fire;
  logic [2*fpms_pkg::PixW-1:0] pix_sq;

  // Snapshot of the ended frame.
  logic [fpms_pkg::CntW-1:0]   n_q;
  logic [fpms_pkg::SumW-1:0]   s_q;
  logic                        ovf_q;

  // Multiplier, divider and root unit registers.
  logic [fpms_pkg::ProdW-1:0]  ssq_q;
  logic [fpms_pkg::ProdW-1:0]  prod_q;
  logic [fpms_pkg::ProdW-1:0]  mcand_q;
  logic [fpms_pkg::CntW-1:0]   mplier_q;
  logic [fpms_pkg::ProdW-1:0]  var_v;
  logic [fpms_pkg::DivW-1:0]   dvd_q;
  logic [fpms_pkg::CntW-1:0]   drem_q;
  logic [fpms_pkg::CntW:0]     drem_sh;
  logic                        dbit;
  logic [fpms_pkg::RadW-1:0]   rad_q;
  logic [fpms_pkg::RootW+1:0]  rrem_q;
  logic [fpms_pkg::RootW-1:0]  root_q;
  logic [fpms_pkg::RootW+3:0]  rrem_sh;
  logic [fpms_pkg::RootW+3:0]  trial;
  logic                        rbit;

  // Result register.
  logic                        out_valid_q;
  logic [fpms_pkg::MeanW-1:0]  out_mean_q;
  logic [fpms_pkg::StdW-1:0]   out_std_q;
  logic [fpms_pkg::CntW-1:0]   out_total_q;
  logic                        out_ovf_q;

  // Input stalls only while an ended frame waits for its snapshot.
  assign s_axis_tready = !end_pend_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pix_sq        = s_axis_tdata * s_axis_tdata;

  assign status_o.end_pend = end_pend_q;
  assign status_o.out_free = !out_valid_q || m_axis_tready;

  // Accumulate counted pixels; the snapshot clears them for the next frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cnt_q  <= '0;
      acc_sum_q  <= '0;
      acc_sq_q   <= '0;
      acc_ovf_q  <= 1'b0;
      end_pend_q <= 1'b0;
    end else if (cmd_i.snap) begin
      acc_cnt_q  <= '0;
      acc_sum_q  <= '0;
      acc_sq_q   <= '0;
      acc_ovf_q  <= 1'b0;
      end_pend_q <= 1'b0;
    end else if (in_fire) begin
      if (acc_cnt_q < fpms_pkg::MaxPixels) begin
        acc_cnt_q <= acc_cnt_q + 1'b1;
        acc_sum_q <= acc_sum_q + fpms_pkg::SumW'(s_axis_tdata);
        acc_sq_q  <= acc_sq_q + fpms_pkg::SqSumW'(pix_sq);
      end else begin
        acc_ovf_q <= 1'b1;
      end
      if (s_axis_tlast) begin
        end_pend_q <= 1'b1;
      end
    end
  end

  // Snapshot and n*Q by shift and add over the bits of n.
  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      n_q      <= acc_cnt_q;
      s_q      <= acc_sum_q;
      ovf_q    <= acc_ovf_q;
      prod_q   <= '0;
      mcand_q  <= fpms_pkg::ProdW'(acc_sq_q);
      mplier_q <= acc_cnt_q;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= {mcand_q[fpms_pkg::ProdW-2:0], 1'b0};
      mplier_q <= mplier_q >> 1;
    end
  end

  // S*S is registered from the stable snapshot.
  always_ff @(posedge clk_i) begin
    ssq_q <= fpms_pkg::ProdW'(s_q * s_q);
  end

  // n^2 times the variance; never negative.
  assign var_v = prod_q - ssq_q;

  // Restoring division step by n.
  assign drem_sh = {drem_q, dvd_q[fpms_pkg::DivW-1]};
  assign dbit    = (drem_sh >= {1'b0, n_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.var_load) begin
      dvd_q  <= {var_v, 16'h0000};
      drem_q <= '0;
    end else if (cmd_i.div_redo) begin
      drem_q <= '0;
    end else if (cmd_i.root_load) begin
      dvd_q  <= fpms_pkg::DivW'({s_q, 8'h00});
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[fpms_pkg::DivW-2:0], dbit};
      if (dbit) begin
        drem_q <= fpms_pkg::CntW'(drem_sh - {1'b0, n_q});
      end else begin
        drem_q <= drem_sh[fpms_pkg::CntW-1:0];
      end
    end
  end

  // Square root, one result bit per step.
  assign rrem_sh = {rrem_q, rad_q[fpms_pkg::RadW-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign rbit    = (rrem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_load) begin
      rad_q  <= dvd_q[fpms_pkg::RadW-1:0];
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[fpms_pkg::RadW-3:0], 2'b00};
      root_q <= {root_q[fpms_pkg::RootW-2:0], rbit};
      if (rbit) begin
        rrem_q <= (fpms_pkg::RootW+2)'(rrem_sh - trial);
      end else begin
        rrem_q <= rrem_sh[fpms_pkg::RootW+1:0];
      end
    end
  end

  // Result register; an empty frame reports zero mean and deviation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (n_q == '0) begin
        out_mean_q <= '0;
        out_std_q  <= '0;
      end else begin
        out_mean_q <= dvd_q[fpms_pkg::MeanW-1:0];
        out_std_q  <= root_q[fpms_pkg::StdW-1:0];
      end
      out_total_q <= n_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = fpms_pkg::OutDataW'({out_total_q, out_std_q, out_mean_q});
  assign m_axis_tuser  = out_ovf_q;

endmodule

// File: bench/frame_pixel_mean_and_std_top_test.sv
// Self-checking bench for the frame pixel mean and standard deviation block.
module frame_pixel_mean_and_std_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One frame result, as carried on the output stream.
  typedef struct packed {
    logic [fpms_pkg::MeanW-1:0] mean_q8;
    logic [fpms_pkg::StdW-1:0]  std_q8;
    logic [fpms_pkg::CntW-1:0]  pixel_total;
    logic                       overflow;
  } frame_stats_t;

  // One row of the directed table; fixed rows carry a hand-worked result.
  typedef struct packed {
    logic [fpms_pkg::PixW-1:0] pixel;
    logic                      last;
    logic                      fixed;
    frame_stats_t              want;
  } pixel_row_t;

  // How the pixel values of a random frame are spread.
  typedef enum int unsigned {
    SPREAD_UNIFORM,
    SPREAD_EXTREME,
    SPREAD_NARROW,
    SPREAD_FLAT
  } spread_e;

  localparam int unsigned IdlePct       = 26;
  localparam int unsigned RandomItems   = 1930;
  localparam int unsigned FullRateItems = 300;
  localparam int unsigned HoldAtResult  = 30;
  localparam int unsigned HoldCycles    = 2000;
  localparam int unsigned DrainCycles   = 400;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DirRows       = 18;

  localparam frame_stats_t NoStats = '0;

  // Directed frames: single extremes, the widest spread, a flat frame,
  // one pixel per bit weight, and an ordinary mix.
  localparam pixel_row_t DirTable [DirRows] = '{
    '{8'd0,   1'b1, 1'b1, '{16'd0,     15'd0,     21'd1, 1'b0}},
    '{8'd255, 1'b1, 1'b1, '{16'd65280, 15'd0,     21'd1, 1'b0}},
    '{8'd0,   1'b0, 1'b0, NoStats},
    '{8'd255, 1'b1, 1'b1, '{16'd32640, 15'd32640, 21'd2, 1'b0}},
    '{8'd128, 1'b0, 1'b0, NoStats},
    '{8'd128, 1'b0, 1'b0, NoStats},
    '{8'd128, 1'b1, 1'b1, '{16'd32768, 15'd0,     21'd3, 1'b0}},
    '{8'd1,   1'b0, 1'b0, NoStats},
    '{8'd2,   1'b0, 1'b0, NoStats},
    '{8'd4,   1'b0, 1'b0, NoStats},
    '{8'd8,   1'b0, 1'b0, NoStats},
    '{8'd16,  1'b0, 1'b0, NoStats},
    '{8'd32,  1'b0, 1'b0, NoStats},
    '{8'd64,  1'b0, 1'b0, NoStats},
    '{8'd128, 1'b1, 1'b0, NoStats},
    '{8'd200, 1'b0, 1'b0, NoStats},
    '{8'd17,  1'b0, 1'b0, NoStats},
    '{8'd99,  1'b1, 1'b0, NoStats}
  };

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [fpms_pkg::PixW-1:0]     s_axis_tdata  = '0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [fpms_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;

  // Running sums of the frame in progress, as the block should hold them.
  bit [63:0]    frame_count = '0;
  bit [63:0]    frame_sum   = '0;
  bit [63:0]    frame_sqsum = '0;
  bit           frame_ovf   = 1'b0;
  frame_stats_t stats_q[$];
  int unsigned  fail_count  = 0;
  bit           full_rate   = 1'b0;

  frame_pixel_mean_and_std_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bitwise integer square root, one result bit per pass from the top.
  function automatic logic [15:0] root_floor(input bit [63:0] radicand);
    bit [15:0] root;
    bit [63:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = 64'(root | (16'd1 << b));
      if (trial * trial <= radicand) root = trial[15:0];
    end
    return root;
  endfunction

  // Adds one pixel to the frame sums; on the final pixel works out the
  // frame result and clears the sums.
  task automatic accumulate_pixel(input logic [fpms_pkg::PixW-1:0] px, input logic lst,
                                  output bit ended, output frame_stats_t stats);
    bit [63:0] n, spread, q1, r1, var_q16, mean_full;
    stats = '0;
    ended = lst;
    if (frame_count < 64'(fpms_pkg::MaxPixels)) begin
      frame_count += 1;
      frame_sum   += 64'(px);
      frame_sqsum += 64'(px) * 64'(px);
    end else begin
      frame_ovf = 1'b1;
    end
    if (lst) begin
      if (frame_count != 0) begin
        n         = frame_count;
        spread    = n * frame_sqsum - frame_sum * frame_sum;
        q1        = spread / n;
        r1        = spread % n;
        var_q16   = ((q1 << 16) + ((r1 << 16) / n)) / n;
        mean_full = (frame_sum << 8) / n;
        stats.mean_q8 = mean_full[fpms_pkg::MeanW-1:0];
        stats.std_q8  = fpms_pkg::StdW'(root_floor(var_q16));
      end
      stats.pixel_total = frame_count[fpms_pkg::CntW-1:0];
      stats.overflow    = frame_ovf;
      frame_count = '0;
      frame_sum   = '0;
      frame_sqsum = '0;
      frame_ovf   = 1'b0;
    end
  endtask

  // Offers one pixel request, waits for it to be taken, then idles at random outside full rate.
  task automatic send_pixel(input logic [fpms_pkg::PixW-1:0] px, input logic lst,
                            input logic fixed, input frame_stats_t want);
    bit           ended;
    frame_stats_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    accumulate_pixel(px, lst, ended, predicted);
    if (ended) stats_q.push_back(fixed ? want : predicted);
    while (!full_rate && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic logic [fpms_pkg::PixW-1:0] pick_pixel(
      input spread_e spread, input logic [fpms_pkg::PixW-1:0] base);
    case (spread)
      SPREAD_UNIFORM: return fpms_pkg::PixW'($urandom_range(255));
      SPREAD_EXTREME: return $urandom_range(1) ? 8'd255 : 8'd0;
      SPREAD_NARROW:  return base ^ fpms_pkg::PixW'($urandom_range(3));
      default:        return base;
    endcase
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endfunction

  // Stimulus: directed table, then random frames, the first stretch at full rate.
  initial begin
    int unsigned  sent;
    int unsigned  len;
    spread_e      spread;
    logic [7:0]   base;
    pixel_row_t   row;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      row = DirTable[i];
      send_pixel(row.pixel, row.last, row.fixed, row.want);
    end

    // Random frames, mostly short, a few long.
    sent = 0;
    while (sent < RandomItems) begin
      full_rate = (sent < FullRateItems);
      case ($urandom_range(19))
        0:             len = $urandom_range(400, 65);
        1, 2, 3, 4, 5: len = $urandom_range(64, 9);
        default:       len = $urandom_range(8, 1);
      endcase
      spread = spread_e'($urandom_range(3));
      base   = fpms_pkg::PixW'($urandom_range(255));
      for (int k = 0; k < len; k++) begin
        send_pixel(pick_pixel(spread, base), k == len - 1, 1'b0, NoStats);
      end
      sent += len;
    end
    full_rate = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result side: check each taken request against the oldest expectation and
  // drive tready, with one long hold-off that backs up the input.
  initial begin
    int unsigned  hold_left;
    int unsigned  result_count;
    frame_stats_t want;
    hold_left    = 0;
    result_count = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (stats_q.size() == 0) begin
          $error("result with no frame pending: tdata %h, tuser %b",
                 m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = stats_q.pop_front();
          compare_field("mean_q8", want.mean_q8, m_axis_tdata[fpms_pkg::MeanW-1:0]);
          compare_field("std_q8", want.std_q8,
                        m_axis_tdata[fpms_pkg::MeanW+fpms_pkg::StdW-1:fpms_pkg::MeanW]);
          compare_field("pixel_total", want.pixel_total,
                        m_axis_tdata[fpms_pkg::OutFieldsW-1:fpms_pkg::MeanW+fpms_pkg::StdW]);
          compare_field("overflow", want.overflow, m_axis_tuser);
        end
        if (result_count == HoldAtResult) hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= full_rate || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet == WatchdogLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule
